// ===== rtl/core/rde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants of the radix digit emitter
// Holds the payload structs, the base selector codes, the derived digit
// widths and the ASCII mapping used by the converter and the emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

	// Bits of the operand that take part in the conversion.
	localparam int VALUE_WIDTH = 31;
	// Fixed width of the operand field on the port.
	localparam int IN_WIDTH    = 31;

	// Digit counts for the largest operand in each base.
	localparam int DEC_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int BCD_WIDTH  = 4 * DEC_DIGITS;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Width of the emitter shift register: large enough for every base.
	localparam int DIG_WIDTH = max_int(max_int(BCD_WIDTH, VALUE_WIDTH),
		max_int(3 * OCT_DIGITS, 4 * HEX_DIGITS));

	// Counter width for digits and for conversion steps.
	localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

	localparam logic [6:0] ASCII_ZERO    = 7'd48;
	localparam logic [6:0] ASCII_UPPER_A = 7'd65;

	typedef enum logic [1:0] {
		FUNC_BIN = 2'd0,
		FUNC_OCT = 2'd1,
		FUNC_DEC = 2'd2,
		FUNC_HEX = 2'd3
	} func_t;

	typedef struct packed {
		logic [IN_WIDTH-1:0] value;
		func_t               func;
	} in_t;

	typedef struct packed {
		logic [6:0] digit_char;
		logic       last;
	} res_t;

	// Load command from the controller to the emitter.
	typedef struct packed {
		logic                 load;
		func_t                base;
		logic [DIG_WIDTH-1:0] data;
	} emit_cmd_t;

	// Maps a digit of 0 to 15 to its ASCII code.
	function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
		if (d >= 4'd10) begin
			return ASCII_UPPER_A + {3'b000, d} - 7'd10;
		end
		return ASCII_ZERO + {3'b000, d};
	endfunction

endpackage

// ===== rtl/core/rde_dabble.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_dabble: bit-serial binary to BCD converter
// Shifts the operand in one bit per cycle, most significant first, and
// applies the add-three correction to every BCD digit before each shift.
// ----------------------------------------------------------------------------
module rde_dabble (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic [rde_pkg::VALUE_WIDTH-1:0]  value,
	output logic                             busy,
	output logic [rde_pkg::BCD_WIDTH-1:0]    bcd
);

	logic [rde_pkg::VALUE_WIDTH-1:0] sh_q;
	logic [rde_pkg::BCD_WIDTH-1:0]   bcd_q;
	logic [rde_pkg::CNT_WIDTH-1:0]   cnt_q;
	logic [rde_pkg::BCD_WIDTH-1:0]   adj;

	// Add three to every digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < rde_pkg::DEC_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Step counter: one operand bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= rde_pkg::CNT_WIDTH'(rde_pkg::VALUE_WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Operand and BCD shift registers.
	always_ff @(posedge clk) begin
		if (go) begin
			sh_q  <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			sh_q  <= sh_q << 1;
			bcd_q <= {adj[rde_pkg::BCD_WIDTH-2:0], sh_q[rde_pkg::VALUE_WIDTH-1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign bcd  = bcd_q;

endmodule

// ===== rtl/core/rde_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_emitter: serial digit emitter
// Shifts a digit vector out one digit per cycle, most significant first,
// drops leading zeros and flags the final digit of the run.
// ----------------------------------------------------------------------------
module rde_emitter (
	input  logic               clk,
	input  logic               arst_n,
	input  rde_pkg::emit_cmd_t cmd,
	output logic               busy,
	output logic               result_valid,
	output rde_pkg::res_t      result
);

	localparam int DW = rde_pkg::DIG_WIDTH;
	localparam int CW = rde_pkg::CNT_WIDTH;

	// Left alignment so that the first digit sits at the top of the register.
	localparam int SH_BIN = DW - rde_pkg::VALUE_WIDTH;
	localparam int SH_OCT = DW - 3 * rde_pkg::OCT_DIGITS;
	localparam int SH_HEX = DW - 4 * rde_pkg::HEX_DIGITS;
	localparam int SH_DEC = DW - rde_pkg::BCD_WIDTH;

	logic [DW-1:0]         dig_q;
	logic [CW-1:0]         rem_q;
	logic                  started_q;
	rde_pkg::func_t        base_q;
	logic                  result_valid_q;
	rde_pkg::res_t         result_q;

	logic [3:0]            top4;
	logic [3:0]            digit;
	logic [DW-1:0]         dig_next;
	logic                  emit;

	// Current digit and the shifted register for the base in use.
	always_comb begin
		top4 = dig_q[DW-1 -: 4];
		unique case (base_q) inside
			rde_pkg::FUNC_BIN: begin
				digit    = {3'b000, top4[3]};
				dig_next = dig_q << 1;
			end
			rde_pkg::FUNC_OCT: begin
				digit    = {1'b0, top4[3:1]};
				dig_next = dig_q << 3;
			end
			rde_pkg::FUNC_DEC, rde_pkg::FUNC_HEX: begin
				digit    = top4;
				dig_next = dig_q << 4;
			end
		endcase
	end

	// A digit goes out once a nonzero one has been seen, or as the final one.
	assign emit = (rem_q != '0) && ((digit != 4'd0) || started_q || (rem_q == CW'(1)));

	// Control: remaining digit count and leading zero tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q          <= '0;
			started_q      <= 1'b0;
			base_q         <= rde_pkg::FUNC_BIN;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;
			if (cmd.load) begin
				base_q    <= cmd.base;
				started_q <= 1'b0;
				unique case (cmd.base)
					rde_pkg::FUNC_BIN: rem_q <= CW'(rde_pkg::VALUE_WIDTH);
					rde_pkg::FUNC_OCT: rem_q <= CW'(rde_pkg::OCT_DIGITS);
					rde_pkg::FUNC_DEC: rem_q <= CW'(rde_pkg::DEC_DIGITS);
					rde_pkg::FUNC_HEX: rem_q <= CW'(rde_pkg::HEX_DIGITS);
				endcase
			end else if (rem_q != '0) begin
				rem_q <= rem_q - 1'b1;
				if (emit) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	// Digit shift register and output payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			unique case (cmd.base)
				rde_pkg::FUNC_BIN: dig_q <= cmd.data << SH_BIN;
				rde_pkg::FUNC_OCT: dig_q <= cmd.data << SH_OCT;
				rde_pkg::FUNC_DEC: dig_q <= cmd.data << SH_DEC;
				rde_pkg::FUNC_HEX: dig_q <= cmd.data << SH_HEX;
			endcase
		end else if (rem_q != '0) begin
			dig_q <= dig_next;
		end
		if (emit) begin
			result_q.digit_char <= rde_pkg::digit_to_ascii(digit);
			result_q.last       <= (rem_q == CW'(1));
		end
	end

	assign busy         = (rem_q != '0);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/core/radix_digit_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter: integer to ASCII digits in base 2, 8, 10 or 16
// Converts one operand and emits its digits most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   An item (operand.value, operand.func) is taken at a clock edge where
//   start is high and busy is low. busy stays high until the final digit of
//   the item has left.
//   Each digit appears on result for one cycle with result_valid high; the
//   final digit of the run has result.last set. Leading zeros are dropped and
//   a zero operand gives a single '0'. The receiver cannot stall the block.
//   Sequence: in binary, octal and hex the digit slots start on the cycle
//   after the item is taken, and each slot's digit is registered onto
//   result in the cycle after its slot. Leading zero slots give no strobe.
//   Decimal first runs a bit-serial BCD conversion of all VALUE_WIDTH
//   operand bits and a load step into the emitter before its first slot.
//   Throughput: one digit slot per cycle, then the controller returns to
//   idle; the next item is taken only after the final digit has left.
//   Reset clears the controller, the counters and result_valid at once.
// ----------------------------------------------------------------------------
module radix_digit_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rde_pkg::in_t  operand,
	output logic          result_valid,
	output rde_pkg::res_t result
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                           state_q;
	logic                             accept;
	logic [63:0]                      value_ext;
	logic [rde_pkg::VALUE_WIDTH-1:0]  value_m;
	logic                             dab_busy;
	logic [rde_pkg::BCD_WIDTH-1:0]    bcd;
	logic                             emit_busy;
	rde_pkg::emit_cmd_t               cmd;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign value_ext = 64'(operand.value);
	assign value_m   = value_ext[rde_pkg::VALUE_WIDTH-1:0];

	// Emitter load: straight from the operand, or from the BCD result.
	always_comb begin
		cmd.load = (accept && (operand.func != rde_pkg::FUNC_DEC))
			|| ((state_q == ST_CONV) && !dab_busy);
		if (accept) begin
			cmd.base = operand.func;
			cmd.data = rde_pkg::DIG_WIDTH'(value_m);
		end else begin
			cmd.base = rde_pkg::FUNC_DEC;
			cmd.data = rde_pkg::DIG_WIDTH'(bcd);
		end
	end

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (operand.func == rde_pkg::FUNC_DEC) ? ST_CONV : ST_EMIT;
					end
				end
				ST_CONV: begin
					if (!dab_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!emit_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	rde_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept && (operand.func == rde_pkg::FUNC_DEC)),
		.value  (value_m),
		.busy   (dab_busy),
		.bcd    (bcd)
	);

	rde_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.busy         (emit_busy),
		.result_valid (result_valid),
		.result       (result)
	);

	// A digit is only strobed when the controller was in the emit state on the previous cycle.
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_EMIT))
		else $error("digit produced outside the emit state");

	// While idle neither the converter nor the emitter is working.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!dab_busy && !emit_busy))
		else $error("datapath active while idle");

	// A taken item keeps the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("block not busy after taking an item");

	// Every digit is an ASCII code from '0' to 'F'.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.digit_char >= rde_pkg::ASCII_ZERO)
			&& (result.digit_char <= (rde_pkg::ASCII_UPPER_A + 7'd5))))
		else $error("digit character out of range");

endmodule

// ===== verif/radix_digit_emitter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_checker: digit predictor and scoreboard
// Watches the command and result channels of the radix digit emitter. Each
// accepted item is converted to its expected ASCII digits, and each digit
// strobed out of the block is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module radix_digit_emitter_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  rde_pkg::in_t  operand,
	input  logic          result_valid,
	input  rde_pkg::res_t result,
	output int            digit_errors,
	output int            digits_pending
);

	localparam int MAX_DIGITS = 64;
	localparam longint unsigned VALUE_MASK = (rde_pkg::VALUE_WIDTH >= 64)
		? 64'hFFFF_FFFF_FFFF_FFFF
		: ((64'd1 << rde_pkg::VALUE_WIDTH) - 64'd1);

	rde_pkg::res_t expected_digits [$];
	int            mismatch_count = 0;

	// Converts one item into its digits, most significant first, and queues them.
	function automatic void predict_digits(input rde_pkg::in_t item);
		longint unsigned rest;
		longint unsigned radix;
		logic [3:0]      lsd_first [MAX_DIGITS];
		int              n;
		rde_pkg::res_t   digit;
		rest = 64'(item.value) & VALUE_MASK;
		case (item.func)
			rde_pkg::FUNC_BIN: radix = 2;
			rde_pkg::FUNC_OCT: radix = 8;
			rde_pkg::FUNC_DEC: radix = 10;
			default:           radix = 16;
		endcase
		// A zero value still yields one digit, since the loop runs at least once.
		n = 0;
		do begin
			lsd_first[n] = 4'(rest % radix);
			rest = rest / radix;
			n++;
		end while (rest != 0 && n < MAX_DIGITS);
		for (int k = n - 1; k >= 0; k--) begin
			if (lsd_first[k] >= 4'd10) begin
				digit.digit_char = rde_pkg::ASCII_UPPER_A + {3'b000, lsd_first[k]} - 7'd10;
			end else begin
				digit.digit_char = rde_pkg::ASCII_ZERO + {3'b000, lsd_first[k]};
			end
			digit.last = (k == 0);
			expected_digits.push_back(digit);
		end
	endfunction

	// Results are checked before a new item is predicted, so the order holds
	// even if an item and a digit meet on the same edge.
	always @(posedge clk) begin
		rde_pkg::res_t want;
		if (!arst_n) begin
			expected_digits.delete();
		end else begin
			if (result_valid === 1'b1) begin
				if (expected_digits.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: unexpected digit char=0x%02h last=%b", $realtime,
							result.digit_char, result.last);
					end
				end else begin
					want = expected_digits.pop_front();
					if (result.digit_char !== want.digit_char || result.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display({"%0t: digit mismatch: expected char=0x%02h last=%b,",
								" got char=0x%02h last=%b"},
								$realtime, want.digit_char, want.last,
								result.digit_char, result.last);
						end
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predict_digits(operand);
			end
		end
		digit_errors   <= mismatch_count;
		digits_pending <= expected_digits.size();
	end

endmodule

// ===== verif/radix_digit_emitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_tb: top level testbench of the radix digit emitter
// Sends directed and random conversion items in all four bases under three
// sender idling profiles. The checker beside the block predicts and compares
// every digit; this module only drives items and reports the verdict.
// ----------------------------------------------------------------------------
module radix_digit_emitter_tb;

	localparam int ITEMS_PER_PHASE = 101;
	localparam int MAX_GAP         = 24;
	localparam int TAIL_CYCLES     = 64;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	rde_pkg::in_t  operand;
	logic          result_valid;
	rde_pkg::res_t result;
	int            digit_errors;
	int            digits_pending;

	radix_digit_emitter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operand      (operand),
		.result_valid (result_valid),
		.result       (result)
	);

	radix_digit_emitter_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operand        (operand),
		.result_valid   (result_valid),
		.result         (result),
		.digit_errors   (digit_errors),
		.digits_pending (digits_pending)
	);

	// Clock with a 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Ends a hung run well beyond the slowest legal one.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Sends one item after a random idle gap and waits until the block takes it.
	// With no gap, start stays high from the previous item.
	task automatic send_item(input logic [rde_pkg::IN_WIDTH-1:0] value,
		input rde_pkg::func_t func, input int idle_pct);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		operand.value <= value;
		operand.func  <= func;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Holds the sender off until every expected digit has come out.
	task automatic drain_digits();
		start <= 1'b0;
		do @(posedge clk); while (digits_pending != 0);
	endtask

	// Mix of small, full-width and right-shifted values, powers of two and one below them.
	function automatic logic [rde_pkg::IN_WIDTH-1:0] pick_value();
		longint unsigned v;
		int              sh;
		case ($urandom_range(3))
			0: v = $urandom_range(255);
			1: v = $urandom();
			2: begin
				sh = $urandom_range(rde_pkg::IN_WIDTH - 1);
				v  = (64'd1 << sh) - $urandom_range(1);
			end
			default: v = $urandom() >> $urandom_range(rde_pkg::IN_WIDTH);
		endcase
		return v[rde_pkg::IN_WIDTH-1:0];
	endfunction

	// Directed items, then three random phases, then the verdict.
	initial begin
		int idle_pct [3];
		logic [rde_pkg::IN_WIDTH-1:0] all_ones;
		idle_pct = '{12, 68, 0};
		all_ones = '1;
		arst_n   = 1'b0;
		start    = 1'b0;
		operand  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero, one and the largest value in every base.
		for (int f = 0; f < 4; f++) begin
			send_item('0, rde_pkg::func_t'(f), idle_pct[0]);
			send_item(1, rde_pkg::func_t'(f), idle_pct[0]);
			send_item(all_ones, rde_pkg::func_t'(f), idle_pct[0]);
		end
		// Digit boundaries: nine and ten, seven and eight, the letters A and F, then wider patterns.
		send_item(9, rde_pkg::FUNC_DEC, idle_pct[0]);
		send_item(10, rde_pkg::FUNC_DEC, idle_pct[0]);
		send_item(1_000_000_000, rde_pkg::FUNC_DEC, idle_pct[0]);
		send_item(7, rde_pkg::FUNC_OCT, idle_pct[0]);
		send_item(8, rde_pkg::FUNC_OCT, idle_pct[0]);
		send_item(10, rde_pkg::FUNC_HEX, idle_pct[0]);
		send_item(15, rde_pkg::FUNC_HEX, idle_pct[0]);
		send_item(31'h0ABC_DEF0, rde_pkg::FUNC_HEX, idle_pct[0]);
		send_item(31'h5555_5555, rde_pkg::FUNC_BIN, idle_pct[0]);
		send_item(31'h4000_0000, rde_pkg::FUNC_BIN, idle_pct[0]);
		drain_digits();

		for (int phase = 0; phase < 3; phase++) begin
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_item(pick_value(), rde_pkg::func_t'($urandom_range(3)), idle_pct[phase]);
			end
			drain_digits();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (digit_errors == 0 && digits_pending == 0) begin
			$display("TB_OK");
		end else begin
			if (digits_pending != 0) begin
				$display("%0d expected digits never came out", digits_pending);
			end
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rde_pkg.sv
rtl/core/rde_dabble.sv
rtl/core/rde_emitter.sv
rtl/core/radix_digit_emitter.sv
verif/radix_digit_emitter_checker.sv
verif/radix_digit_emitter_tb.sv
